[rtl/dmxsr_pkg.sv]
// dmxsr_pkg: shared types and constants of the dmx512 slot receiver
// no dependencies; compiled first
package dmxsr_pkg;

   localparam logic [7:0] START_CODE_RESET = 8'd0;
   localparam logic [7:0] BASE_ADDR_LO     = 8'd1;
   localparam logic [7:0] BASE_ADDR_HI     = 8'd255;
   localparam logic [9:0] SLOT_MAX         = 10'd1023;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE     = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_BREAK = 2'd1,
      PH_DATA  = 2'd2
   } phase_type;

   localparam logic RSP_STATUS = 1'b0;
   localparam logic RSP_DUMP   = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [1:0] rx_state;
      logic       slot_stored;
      logic [3:0] channel_index;
      logic [7:0] channel_value;
      logic       last;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic dump_read;
      logic dump_load;
   } dmxsr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dump_hit;
      logic out_free;
      logic cnt_last;
   } dmxsr_sts_type;

endpackage

[rtl/dmxsr_ifs.sv]
// dmxsr_ifs: request and response channel interfaces (valid/ready)
// no dependencies; compiled after dmxsr_pkg
interface dmxsr_req_if;
   logic       valid;
   logic       ready;
   logic       overrun;
   logic       framing_error;
   logic [7:0] data_byte;

   modport source (output valid, output overrun, output framing_error, output data_byte,
                   input ready);
   modport sink (input valid, input overrun, input framing_error, input data_byte,
                 output ready);
endinterface

interface dmxsr_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] rx_state;
   logic       slot_stored;
   logic [3:0] channel_index;
   logic [7:0] channel_value;
   logic       last;

   modport source (output valid, output kind, output rx_state, output slot_stored,
                   output channel_index, output channel_value, output last,
                   input ready);
   modport sink (input valid, input kind, input rx_state, input slot_stored,
                 input channel_index, input channel_value, input last,
                 output ready);
endinterface

[rtl/dmxsr_ctrl.sv]
// dmxsr_ctrl: sequencer for request intake and the frame-end channel dump
// depends on dmxsr_pkg
module dmxsr_ctrl
   import dmxsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dmxsr_sts_type sts,
   output dmxsr_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_LOAD = 2'd2
   } state_type;

   state_type state_ff;

   assign req_ready     = (state_ff == ST_IDLE) && sts.out_free;
   assign cmd.take_req  = req_ready && req_valid;
   assign cmd.dump_read = (state_ff == ST_READ);
   assign cmd.dump_load = (state_ff == ST_LOAD) && sts.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.take_req && sts.dump_hit) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (cmd.dump_load) begin
                  state_ff <= sts.cnt_last ? ST_IDLE : ST_READ;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_dump_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.take_req && sts.dump_hit |=> state_ff == ST_READ)
      else $error("dump did not start after last channel stored");

   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_load && sts.cnt_last |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after final dump entry");

   a_no_intake_in_dump: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !cmd.take_req)
      else $error("request taken during dump");

endmodule

[rtl/dmxsr_dp.sv]
// dmxsr_dp: framing state, slot counter, channel store, csr and response register
// depends on dmxsr_pkg
module dmxsr_dp
   import dmxsr_pkg::*;
#(
   parameter int CHANNELS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_overrun,
   input  logic                  req_framing_error,
   input  logic [7:0]            req_data_byte,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  dmxsr_cmd_type         cmd,
   output dmxsr_sts_type         sts
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [10:0] CHAN_SPAN = 11'(CHANNELS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

   logic [7:0]       base_address_ff;
   logic [7:0]       address_offset_ff;
   logic [7:0]       start_code_ff;
   phase_type        phase_ff, phase_in;
   logic [9:0]       slot_ff, slot_in;
   logic [7:0]       store_ff [CHANNELS];
   logic [CHANNELS-1:0] store_vld_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic [7:0]       rd_data_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;

   logic [10:0]      win_start;
   logic [10:0]      slot_ext;
   logic             in_window;
   logic [10:0]      slot_diff;
   logic [IDX_W-1:0] chan_n;
   logic [IDX_W+3:0] chan_n_ext;
   logic [IDX_W+3:0] cnt_ext;
   logic             stored;
   logic [7:0]       csr_base;

   assign win_start  = 11'(base_address_ff) + 11'(address_offset_ff);
   assign slot_ext   = 11'(slot_ff);
   assign in_window  = (slot_ext >= win_start) && (slot_ext < win_start + CHAN_SPAN);
   assign slot_diff  = slot_ext - win_start;
   assign chan_n     = slot_diff[IDX_W-1:0];
   assign chan_n_ext = {4'b0, chan_n};
   assign cnt_ext    = {4'b0, cnt_ff};

   // framing and slot tracking for the request on the port
   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      stored   = 1'b0;
      if (req_overrun) begin
         phase_in = PH_IDLE;
      end else if (req_framing_error) begin
         phase_in = (req_data_byte == 8'd0) ? PH_BREAK : PH_IDLE;
      end else begin
         case (phase_ff)
            PH_BREAK: begin
               if (req_data_byte == start_code_ff) begin
                  phase_in = PH_DATA;
                  slot_in  = 10'd1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               stored = in_window;
               if (slot_ff != SLOT_MAX) begin
                  slot_in = slot_ff + 10'd1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign sts.dump_hit = stored && (chan_n == IDX_LAST);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.cnt_last = (cnt_ff == IDX_LAST);

   // a written zero base address clamps to the minimum
   assign csr_base = (csr_wdata < BASE_ADDR_LO || csr_wdata > BASE_ADDR_HI) ?
                     BASE_ADDR_LO : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff   <= BASE_ADDR_LO;
         address_offset_ff <= 8'd0;
         start_code_ff     <= START_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_ADDRESS:   base_address_ff   <= csr_base;
            CSR_ADDRESS_OFFSET: address_offset_ff <= csr_wdata;
            CSR_START_CODE:     start_code_ff     <= csr_wdata;
            default: begin
               base_address_ff <= base_address_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         slot_ff      <= 10'd0;
         store_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.take_req) begin
            phase_ff <= phase_in;
            slot_ff  <= slot_in;
            cnt_ff   <= '0;
            if (stored) begin
               store_vld_ff[chan_n] <= 1'b1;
            end
         end else if (cmd.dump_load) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
         end
         if (cmd.take_req || cmd.dump_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // channel store and its registered read port
   always_ff @(posedge clock) begin
      if (cmd.take_req && stored) begin
         store_ff[chan_n] <= req_data_byte;
      end
      if (cmd.dump_read) begin
         rd_data_ff <= store_vld_ff[cnt_ff] ? store_ff[cnt_ff] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         rsp_item_ff.kind          <= RSP_STATUS;
         rsp_item_ff.rx_state      <= phase_in;
         rsp_item_ff.slot_stored   <= stored;
         rsp_item_ff.channel_index <= stored ? chan_n_ext[3:0] : 4'd0;
         rsp_item_ff.channel_value <= stored ? req_data_byte : 8'd0;
         rsp_item_ff.last          <= !sts.dump_hit;
      end else if (cmd.dump_load) begin
         rsp_item_ff.kind          <= RSP_DUMP;
         rsp_item_ff.rx_state      <= phase_ff;
         rsp_item_ff.slot_stored   <= 1'b0;
         rsp_item_ff.channel_index <= cnt_ext[3:0];
         rsp_item_ff.channel_value <= rd_data_ff;
         rsp_item_ff.last          <= sts.cnt_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_slot_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> slot_ff != 10'd0)
      else $error("data phase with zero slot count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.kind == RSP_STATUS && !rsp_item_ff.slot_stored
      |-> rsp_item_ff.channel_index == 4'd0 && rsp_item_ff.channel_value == 8'd0)
      else $error("status without store carries channel data");

   a_base_clamped: assert property (@(posedge clock) disable iff (reset)
      base_address_ff != 8'd0)
      else $error("base address register holds zero");

endmodule

[rtl/dmx512_slot_receiver_top.sv]
// channel   direction  handshake        payload
// req_if    in         valid/ready      overrun, framing_error, data_byte
// rsp_if    out        valid/ready      kind, rx_state, slot_stored, channel_index,
//                                       channel_value, last
// csr_*     in         csr_we strobe    csr_index, csr_wdata
//
// a request is taken when valid and ready are both high; its status response sits in the
// output register on the next cycle. a request that stores the last channel adds a dump
// with one store read and one output load per channel; each load waits until the output
// register is free.
// reset is synchronous and clears framing state, slot counter, store valid bits and csrs.
// req_if.ready drops during a dump and while an undelivered response is not being taken.
// depends on dmxsr_pkg, dmxsr_ifs, dmxsr_ctrl, dmxsr_dp
module dmx512_slot_receiver_top
   import dmxsr_pkg::*;
#(
   parameter int CHANNELS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   dmxsr_req_if.sink             req_if,
   dmxsr_rsp_if.source           rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dmxsr_cmd_type cmd;
   dmxsr_sts_type sts;
   logic          req_ready;
   logic          rsp_valid;
   rsp_item_type  rsp_item;

   dmxsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dmxsr_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_overrun       (req_if.overrun),
      .req_framing_error (req_if.framing_error),
      .req_data_byte     (req_if.data_byte),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_valid),
      .rsp_item          (rsp_item),
      .cmd               (cmd),
      .sts               (sts)
   );

   assign req_if.ready         = req_ready;
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.kind          = rsp_item.kind;
   assign rsp_if.rx_state      = rsp_item.rx_state;
   assign rsp_if.slot_stored   = rsp_item.slot_stored;
   assign rsp_if.channel_index = rsp_item.channel_index;
   assign rsp_if.channel_value = rsp_item.channel_value;
   assign rsp_if.last          = rsp_item.last;

endmodule

[verif/dmxsr_frame_monitor.sv]
// dmxsr_frame_monitor: follows dmx512 framing on the request channel, predicts every response
// and compares what leaves the response channel; depends on dmxsr_pkg and dmxsr_ifs
`timescale 1ns / 100ps

module dmxsr_frame_monitor
   import dmxsr_pkg::*;
#(
   parameter int CHANNELS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   dmxsr_req_if                  req_mon,
   dmxsr_rsp_if                  rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    open_count
);

   rsp_item_type rsp_due_q[$];

   phase_type  rx_phase;
   logic [9:0] slot_num;
   logic [7:0] chan_mem [CHANNELS];
   logic [7:0] base_addr;
   logic [7:0] addr_offset;
   logic [7:0] start_code;

   // one received uart event: update framing and queue the responses it causes
   task automatic track_slot(input logic ovr, input logic ferr, input logic [7:0] rx_byte);
      rsp_item_type entry;
      int win_lo;
      int rel;
      bit hit;
      bit dump;
      hit = 0;
      dump = 0;
      rel = 0;
      win_lo = int'(base_addr) + int'(addr_offset);
      if (ovr) begin
         rx_phase = PH_IDLE;
      end else if (ferr) begin
         rx_phase = (rx_byte == 8'd0) ? PH_BREAK : PH_IDLE;
      end else if (rx_phase == PH_BREAK) begin
         if (rx_byte == start_code) begin
            rx_phase = PH_DATA;
            slot_num = 10'd1;
         end else begin
            rx_phase = PH_IDLE;
         end
      end else if (rx_phase == PH_DATA) begin
         if (int'(slot_num) >= win_lo && int'(slot_num) < win_lo + CHANNELS) begin
            rel = int'(slot_num) - win_lo;
            chan_mem[rel] = rx_byte;
            hit = 1;
            dump = (rel == CHANNELS - 1);
         end
         // counter sticks at the top slot
         if (slot_num != SLOT_MAX) slot_num = slot_num + 10'd1;
      end
      entry.kind          = RSP_STATUS;
      entry.rx_state      = rx_phase;
      entry.slot_stored   = hit;
      entry.channel_index = hit ? rel[3:0] : 4'd0;
      entry.channel_value = hit ? rx_byte : 8'd0;
      entry.last          = !dump;
      rsp_due_q.push_back(entry);
      if (dump) begin
         for (int i = 0; i < CHANNELS; i++) begin
            entry.kind          = RSP_DUMP;
            entry.rx_state      = rx_phase;
            entry.slot_stored   = 1'b0;
            entry.channel_index = i[3:0];
            entry.channel_value = chan_mem[i];
            entry.last          = (i == CHANNELS - 1);
            rsp_due_q.push_back(entry);
         end
      end
   endtask

   function automatic int field_diff(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // sampled at the falling edge: these are the values the block sees at the next rising edge
   always @(negedge clock) begin : watch
      rsp_item_type want;
      int bad;
      if (reset) begin
         rsp_due_q.delete();
         rx_phase = PH_IDLE;
         slot_num = 10'd0;
         foreach (chan_mem[i]) chan_mem[i] = 8'd0;
         base_addr = 8'd1;
         addr_offset = 8'd0;
         start_code = 8'd0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rsp_due_q.size() == 0) begin
               $display("%0t: response with nothing expected, kind %0d index %0d value %0d",
                        $time, rsp_mon.kind, rsp_mon.channel_index, rsp_mon.channel_value);
               fail_count++;
            end else begin
               want = rsp_due_q.pop_front();
               bad = 0;
               bad += field_diff("kind", 8'(want.kind), 8'(rsp_mon.kind));
               bad += field_diff("rx_state", 8'(want.rx_state), 8'(rsp_mon.rx_state));
               bad += field_diff("slot_stored", 8'(want.slot_stored), 8'(rsp_mon.slot_stored));
               bad += field_diff("channel_index", 8'(want.channel_index),
                                 8'(rsp_mon.channel_index));
               bad += field_diff("channel_value", want.channel_value, rsp_mon.channel_value);
               bad += field_diff("last", 8'(want.last), 8'(rsp_mon.last));
               if (bad != 0) fail_count++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            track_slot(req_mon.overrun, req_mon.framing_error, req_mon.data_byte);
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_ADDRESS: begin
                  base_addr = (csr_wdata < BASE_ADDR_LO || csr_wdata > BASE_ADDR_HI)
                              ? BASE_ADDR_LO : csr_wdata;
               end
               CSR_ADDRESS_OFFSET: addr_offset = csr_wdata;
               CSR_START_CODE: start_code = csr_wdata;
               default: ;
            endcase
         end
      end
      open_count <= rsp_due_q.size();
   end

endmodule

[verif/testbench.sv]
// testbench: drives dmx512 framing traffic and register settings into dmx512_slot_receiver_top
// and reports the verdict; depends on dmxsr_pkg, dmxsr_ifs and dmxsr_frame_monitor
`timescale 1ns / 100ps

module testbench;
   import dmxsr_pkg::*;

   localparam int CHANNELS = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int LONG_HOLD = 300;
   localparam int STALL_LIMIT = 3000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int open_count;
   int stall_cycles;
   int items_sent;
   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_ticket;
   int win_lo;
   logic [7:0] cur_start;

   dmxsr_req_if req_ch ();
   dmxsr_rsp_if rsp_ch ();

   dmx512_slot_receiver_top #(.CHANNELS(CHANNELS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dmxsr_frame_monitor #(.CHANNELS(CHANNELS)) frame_mon (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side: random stalls, plus a long hold-off whenever the ticket moves
   initial begin
      int hold_left;
      int seen_ticket;
      hold_left = 0;
      seen_ticket = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != seen_ticket) begin
            seen_ticket = hold_ticket;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge that takes the request
   task automatic send_req(input logic ovr, input logic ferr, input logic [7:0] rx_byte);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.overrun <= ovr;
      req_ch.framing_error <= ferr;
      req_ch.data_byte <= rx_byte;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic send_noise();
      send_req(1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom_range(1) ? 8'($urandom()) : 8'd0);
   endtask

   // break, start code, then data slots; a dirty frame may carry errors and a bad start code
   task automatic send_frame(input int n_slots, input bit clean);
      send_req(1'b0, 1'b1, 8'd0);
      if (!clean && $urandom_range(7) == 0)
         send_req(1'b0, 1'b0, cur_start ^ 8'($urandom_range(1, 255)));
      else
         send_req(1'b0, 1'b0, cur_start);
      for (int k = 0; k < n_slots; k++) begin
         if (!clean && $urandom_range(39) == 0)
            send_noise();
         else
            send_req(1'b0, 1'b0, 8'($urandom()));
      end
   endtask

   task automatic random_traffic(input int quota);
      int target;
      int pick;
      target = items_sent + quota;
      while (items_sent < target) begin
         pick = $urandom_range(9);
         if (pick == 0)
            send_noise();
         else if (pick == 1)
            send_frame($urandom_range(1, win_lo + 8), 1'b0);
         else
            send_frame(win_lo + 15 + $urandom_range(3), pick > 6);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   // leaves csr_we high; the caller lowers it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_window(input logic [7:0] base, input logic [7:0] offs,
                                 input logic [7:0] sc);
      write_reg(CSR_BASE_ADDRESS, base);
      write_reg(CSR_ADDRESS_OFFSET, offs);
      write_reg(CSR_START_CODE, sc);
      csr_we <= 1'b0;
      win_lo = ((base == 8'd0) ? 1 : int'(base)) + int'(offs);
      cur_start = sc;
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.overrun = 1'b0;
      req_ch.framing_error = 1'b0;
      req_ch.data_byte = 8'd0;
      csr_we = 1'b0;
      csr_index = CSR_BASE_ADDRESS;
      csr_wdata = 8'd0;
      items_sent = 0;
      hold_ticket = 0;
      sender_idle_pct = 27;
      receiver_idle_pct = 60;
      win_lo = 1;
      cur_start = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // a write past the last register must leave the settings alone
      write_reg(CSR_UNMAPPED, 8'hFF);
      program_window(8'd1, 8'd0, 8'd0);

      // directed: stray byte while idle, overrun beating framing error, framing error,
      // break with wrong start code, overrun, then a full frame that fills the window
      send_req(1'b0, 1'b0, 8'hFF);
      send_req(1'b1, 1'b1, 8'h00);
      send_req(1'b0, 1'b1, 8'h80);
      send_req(1'b0, 1'b1, 8'h00);
      send_req(1'b0, 1'b0, 8'h55);
      send_req(1'b1, 1'b0, 8'hFF);
      send_req(1'b0, 1'b1, 8'h00);
      send_req(1'b0, 1'b0, 8'h00);
      for (int k = 0; k < CHANNELS; k++)
         send_req(1'b0, 1'b0, (k == 0) ? 8'hFF : 8'(k * 17 - 17));
      wait_drained();

      // base written as zero clamps to the first slot
      program_window(8'd0, 8'($urandom_range(3)), 8'hFF);
      random_traffic(15);
      hold_ticket++;
      random_traffic(10);
      wait_drained();

      sender_idle_pct = 60;
      receiver_idle_pct = 27;
      program_window(8'($urandom_range(2, 6)), 8'd0, 8'($urandom_range(1, 254)));
      random_traffic(12);
      wait_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      // window at the far end of the address range, out of reach of a short frame
      program_window(8'd255, 8'd255, 8'd0);
      send_frame(10, 1'b1);
      wait_drained();
      program_window(8'($urandom_range(1, 4)), 8'($urandom_range(2)), 8'($urandom()));
      random_traffic(12);
      wait_drained();

      repeat (40) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[dmx512_slot_receiver_top.f]
rtl/dmxsr_pkg.sv
rtl/dmxsr_ifs.sv
rtl/dmxsr_ctrl.sv
rtl/dmxsr_dp.sv
rtl/dmx512_slot_receiver_top.sv
verif/dmxsr_frame_monitor.sv
verif/testbench.sv
